### rtl/sedb_pkg.sv
// Shared types, constants and helpers for the serpentine error-diffusion binarizer.
package sedb_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned COL_W = 11;
  localparam int unsigned ERR_W = 7;
  localparam int unsigned LW_W = 12;
  localparam int unsigned TGT_W = COL_W + 1;
  localparam int unsigned SUM_W = 10;

  localparam int unsigned MAX_WIDTH = 2048;
  // Error store is split into even and odd column banks.
  localparam int unsigned BANK_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int unsigned BANK_AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  localparam logic [LW_W-1:0] LW_RESET = LW_W'(2048);
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
  localparam logic [ERR_W-1:0] ERR_MAX = 7'h7F;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] column;
    logic             reverse_row;
    logic             row_start;
    logic             first_row;
  } sedb_item_t;

  typedef struct packed {
    logic             col_we;
    logic [ERR_W-1:0] col_wdata;
    logic             tgt_we;
    logic [ERR_W-1:0] tgt_wdata;
    logic [ERR_W-1:0] carry_next;
    logic [PIX_W-1:0] bin;
  } sedb_upd_t;

  // Column that receives the diagonal share: behind the pixel in scan order.
  function automatic logic [TGT_W-1:0] tgt_addr(input logic [COL_W-1:0] col,
                                                input logic rev);
    logic [TGT_W-1:0] c;
    c = {1'b0, col};
    return rev ? c + TGT_W'(1) : c - TGT_W'(1);
  endfunction

  function automatic logic [BANK_AW-1:0] bank_idx(input logic [TGT_W-1:0] a);
    return BANK_AW'(a >> 1);
  endfunction

endpackage

### rtl/sedb_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
module sedb_ram #(
  parameter int unsigned Depth = 2,
  parameter int unsigned AddrW = 1,
  parameter int unsigned DataW = 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sedb_diffuse.sv
// Threshold and error split for one pixel; produces store updates and new carry.
module sedb_diffuse (
  input  sedb_pkg::sedb_item_t         item_i,
  input  logic [sedb_pkg::ERR_W-1:0]   carry_i,
  input  logic [sedb_pkg::ERR_W-1:0]   col_rd_i,
  input  logic [sedb_pkg::ERR_W-1:0]   tgt_rd_i,
  input  logic [sedb_pkg::LW_W-1:0]    line_width_i,
  output sedb_pkg::sedb_upd_t          upd_o
);
  import sedb_pkg::*;

  logic             in_store;
  logic [ERR_W-1:0] stored;
  logic [ERR_W-1:0] carry;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] resid;
  logic [ERR_W-1:0] half;
  logic [ERR_W-2:0] quarter;
  logic [TGT_W-1:0] tgt;
  logic             diag_ok;
  logic [ERR_W:0]   diag_sum;

  always_comb begin
    in_store = 32'(item_i.column) < MAX_WIDTH;
    stored  = (item_i.first_row || !in_store) ? '0 : col_rd_i;
    carry   = item_i.row_start ? '0 : carry_i;
    sum     = SUM_W'(item_i.pixel) + SUM_W'(carry) + SUM_W'(stored);
    // sum stays below twice 255, so one subtract gives the remainder
    resid   = (sum >= SUM_W'(PIX_MAX)) ? sum - SUM_W'(PIX_MAX) : sum;
    half    = resid[ERR_W:1];
    quarter = half[ERR_W-1:1];

    tgt     = tgt_addr(item_i.column, item_i.reverse_row);
    diag_ok = (item_i.reverse_row || (item_i.column != '0)) &&
              (tgt < line_width_i) && (32'(tgt) < MAX_WIDTH);
    diag_sum = (ERR_W+1)'(tgt_rd_i) + (ERR_W+1)'(quarter);

    upd_o.col_we     = in_store;
    upd_o.col_wdata  = ERR_W'(quarter);
    upd_o.tgt_we     = diag_ok;
    upd_o.tgt_wdata  = diag_sum[ERR_W] ? ERR_MAX : diag_sum[ERR_W-1:0];
    upd_o.carry_next = half;
    upd_o.bin        = (sum >= SUM_W'(PIX_MAX)) ? PIX_MAX : '0;
  end

endmodule

### rtl/serpentine_error_diffusion_binarize_core.sv
// Serpentine Sierra-lite error-diffusion binarizer, top level.
//
// Accepts one pixel per clock sustained while the output is not stalled
// and returns one 0/255 pixel per input beat through stage 1 and an
// output register, so the next beat is taken while a result waits. The
// row error store sits in two single-write RAMs, even and odd columns, so
// the pixel's own column and its diagonal neighbor (always the other
// parity) are read on accept and written back as the pixel leaves stage 1;
// a same-cycle write to an entry being read is forwarded. After reset a
// clearing pass over all BANK_DEPTH entries (1024 by default) zeroes
// both banks with in_ready_o low; line_width writes are taken at any time.
module serpentine_error_diffusion_binarize_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sedb_pkg::LW_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sedb_pkg::PIX_W-1:0]    pixel_i,
  input  logic [sedb_pkg::COL_W-1:0]    column_i,
  input  logic                          reverse_row_i,
  input  logic                          row_start_i,
  input  logic                          first_row_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sedb_pkg::PIX_W-1:0]    binary_pixel_o,
  output logic [sedb_pkg::COL_W-1:0]    out_column_o
);
  import sedb_pkg::*;

  logic [LW_W-1:0]    lw_q;
  logic               clr_busy_q, clr_busy_d;
  logic [BANK_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic               s1_valid_q, s1_valid_d;
  sedb_item_t         s1_item_q;
  logic [ERR_W-1:0]   carry_q;
  logic               out_valid_q, out_valid_d;
  logic [PIX_W-1:0]   bin_q;
  logic [COL_W-1:0]   out_col_q;
  logic               fwd_even_q, fwd_odd_q;
  logic [ERR_W-1:0]   fwd_even_data_q, fwd_odd_data_q;

  logic               accept;
  logic               s1_fire;
  logic [BANK_AW-1:0] in_cidx, in_tidx, rd_even_addr, rd_odd_addr;
  logic [BANK_AW-1:0] s1_cidx, s1_tidx;
  logic [ERR_W-1:0]   ram_even_rd, ram_odd_rd, even_rd, odd_rd;
  logic [ERR_W-1:0]   col_rd, tgt_rd;
  logic               wr_even_we, wr_odd_we;
  logic [BANK_AW-1:0] wr_even_addr, wr_odd_addr;
  logic [ERR_W-1:0]   wr_even_data, wr_odd_data;
  sedb_upd_t          upd;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_busy_q && (!s1_valid_q || s1_fire);
  assign accept     = in_valid_i && in_ready_o;

  // read side: own column in its parity bank, diagonal target in the other
  always_comb begin
    in_cidx      = bank_idx({1'b0, column_i});
    in_tidx      = bank_idx(tgt_addr(column_i, reverse_row_i));
    rd_even_addr = column_i[0] ? in_tidx : in_cidx;
    rd_odd_addr  = column_i[0] ? in_cidx : in_tidx;
  end

  assign even_rd = fwd_even_q ? fwd_even_data_q : ram_even_rd;
  assign odd_rd  = fwd_odd_q  ? fwd_odd_data_q  : ram_odd_rd;
  assign col_rd  = s1_item_q.column[0] ? odd_rd  : even_rd;
  assign tgt_rd  = s1_item_q.column[0] ? even_rd : odd_rd;

  sedb_diffuse u_diffuse (
    .item_i       (s1_item_q),
    .carry_i      (carry_q),
    .col_rd_i     (col_rd),
    .tgt_rd_i     (tgt_rd),
    .line_width_i (lw_q),
    .upd_o        (upd)
  );

  // write side: clearing pass has priority, no beat is taken meanwhile
  always_comb begin
    s1_cidx = bank_idx({1'b0, s1_item_q.column});
    s1_tidx = bank_idx(tgt_addr(s1_item_q.column, s1_item_q.reverse_row));
    if (clr_busy_q) begin
      wr_even_we   = 1'b1;
      wr_odd_we    = 1'b1;
      wr_even_addr = clr_cnt_q;
      wr_odd_addr  = clr_cnt_q;
      wr_even_data = '0;
      wr_odd_data  = '0;
    end else if (s1_item_q.column[0]) begin
      wr_even_we   = s1_fire && upd.tgt_we;
      wr_odd_we    = s1_fire && upd.col_we;
      wr_even_addr = s1_tidx;
      wr_odd_addr  = s1_cidx;
      wr_even_data = upd.tgt_wdata;
      wr_odd_data  = upd.col_wdata;
    end else begin
      wr_even_we   = s1_fire && upd.col_we;
      wr_odd_we    = s1_fire && upd.tgt_we;
      wr_even_addr = s1_cidx;
      wr_odd_addr  = s1_tidx;
      wr_even_data = upd.col_wdata;
      wr_odd_data  = upd.tgt_wdata;
    end
  end

  sedb_ram #(
    .Depth (BANK_DEPTH),
    .AddrW (BANK_AW),
    .DataW (ERR_W)
  ) u_ram_even (
    .clk_i   (clk_i),
    .we_i    (wr_even_we),
    .waddr_i (wr_even_addr),
    .wdata_i (wr_even_data),
    .re_i    (accept),
    .raddr_i (rd_even_addr),
    .rdata_o (ram_even_rd)
  );

  sedb_ram #(
    .Depth (BANK_DEPTH),
    .AddrW (BANK_AW),
    .DataW (ERR_W)
  ) u_ram_odd (
    .clk_i   (clk_i),
    .we_i    (wr_odd_we),
    .waddr_i (wr_odd_addr),
    .wdata_i (wr_odd_data),
    .re_i    (accept),
    .raddr_i (rd_odd_addr),
    .rdata_o (ram_odd_rd)
  );

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + BANK_AW'(1);
      if (clr_cnt_q == BANK_AW'(BANK_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
    s1_valid_d = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
    out_valid_d = s1_fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q        <= LW_RESET;
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      carry_q     <= '0;
      fwd_even_q  <= 1'b0;
      fwd_odd_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lw_q <= cfg_wdata_i;
      end
      clr_busy_q  <= clr_busy_d;
      clr_cnt_q   <= clr_cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        carry_q <= upd.carry_next;
      end
      // same-cycle write to the entry being read: RAM data is stale
      if (accept) begin
        fwd_even_q <= wr_even_we && (wr_even_addr == rd_even_addr);
        fwd_odd_q  <= wr_odd_we && (wr_odd_addr == rd_odd_addr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q.pixel       <= pixel_i;
      s1_item_q.column      <= column_i;
      s1_item_q.reverse_row <= reverse_row_i;
      s1_item_q.row_start   <= row_start_i;
      s1_item_q.first_row   <= first_row_i;
      fwd_even_data_q       <= wr_even_data;
      fwd_odd_data_q        <= wr_odd_data;
    end
    if (s1_fire) begin
      bin_q     <= upd.bin;
      out_col_q <= s1_item_q.column;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign binary_pixel_o = bin_q;
  assign out_column_o   = out_col_q;

endmodule

### tb/sv/serpentine_error_diffusion_binarize_core_tb.sv
// Testbench for the serpentine error-diffusion binarizer core.
`timescale 1ns / 1ps

module serpentine_error_diffusion_binarize_core_tb;
  import sedb_pkg::*;

  localparam int unsigned WDOG_LIMIT = 4096;  // outlasts the clearing pass after reset
  localparam int unsigned DRAIN_HOLD = 4;
  localparam int unsigned FRAME_END = 700;
  localparam int unsigned TOTAL_ITEMS = 950;

  typedef struct packed {
    logic [PIX_W-1:0] bin;
    logic [COL_W-1:0] column;
  } dither_beat_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [LW_W-1:0]     cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [PIX_W-1:0]    pixel_i;
  logic [COL_W-1:0]    column_i;
  logic                reverse_row_i;
  logic                row_start_i;
  logic                first_row_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [PIX_W-1:0]    binary_pixel_o;
  logic [COL_W-1:0]    out_column_o;

  // predictor state
  logic [ERR_W-1:0]    row_err_q [MAX_WIDTH];
  logic [ERR_W-1:0]    carry_err_q;
  logic [LW_W-1:0]     lw_q;
  dither_beat_t        expected_px[$];

  int unsigned err_cnt;
  int unsigned sent_cnt;
  int unsigned checked_cnt;
  int unsigned lw_writes;
  int unsigned frame_cnt;
  int unsigned stray_cnt;
  int unsigned burst_left;
  int unsigned stall_mode;
  int unsigned stall_left;
  int unsigned stall_cyc;

  serpentine_error_diffusion_binarize_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_i        (pixel_i),
    .column_i       (column_i),
    .reverse_row_i  (reverse_row_i),
    .row_start_i    (row_start_i),
    .first_row_i    (first_row_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .binary_pixel_o (binary_pixel_o),
    .out_column_o   (out_column_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Threshold one pixel and spread its residual; updates the predictor state.
  function automatic dither_beat_t dither_pixel(input sedb_item_t px);
    int unsigned stored, sum, half, quarter, tgt, acc;
    bit          has_tgt;
    dither_beat_t res;
    if (px.row_start) carry_err_q = '0;
    stored  = px.first_row ? 0 : row_err_q[px.column];
    sum     = px.pixel + carry_err_q + stored;
    half    = (sum % 255) / 2;
    quarter = half / 2;
    carry_err_q = ERR_W'(half);
    // column is 11 bits wide, so it always lands inside the store
    row_err_q[px.column] = ERR_W'(quarter);
    has_tgt = px.reverse_row || (px.column != 0);
    tgt     = px.reverse_row ? px.column + 1 : px.column - 1;
    if (has_tgt && tgt < MAX_WIDTH && tgt < lw_q) begin
      acc = row_err_q[tgt] + quarter;
      row_err_q[tgt] = (acc > ERR_MAX) ? ERR_MAX : ERR_W'(acc);
    end
    res.bin    = (sum >= 255) ? PIX_MAX : '0;
    res.column = px.column;
    return res;
  endfunction

  // Result check first, then new expectation: a result never belongs to a beat
  // taken at the same edge.
  always @(posedge clk_i) begin : scoreboard
    dither_beat_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        checked_cnt++;
        if (expected_px.size() == 0) begin
          $error("result beat with nothing expected: binary_pixel=%0d out_column=%0d",
                 binary_pixel_o, out_column_o);
          err_cnt++;
        end else begin
          want = expected_px.pop_front();
          if (binary_pixel_o !== want.bin) begin
            $error("binary_pixel mismatch: expected %0d, got %0d", want.bin, binary_pixel_o);
            err_cnt++;
          end
          if (out_column_o !== want.column) begin
            $error("out_column mismatch: expected %0d, got %0d", want.column, out_column_o);
            err_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_o)
        expected_px.push_back(dither_pixel({pixel_i, column_i, reverse_row_i,
                                            row_start_i, first_row_i}));
      if (cfg_we_i) lw_q = cfg_wdata_i;
    end
  end

  // Output side: backpressure mode is redrawn whenever stall_left runs out.
  always @(posedge clk_i) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= ((stall_cyc % 12) >= 8);
    endcase
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no beat moved for %0d cycles", WDOG_LIMIT);
    $display("** serpentine_error_diffusion_binarize_core: FAILED **");
    $finish;
  end

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return PIX_MAX;
      2: return PIX_W'($urandom_range(126, 129));
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Drives one pixel beat and holds it until taken; gaps follow each burst.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic [COL_W-1:0] col,
                            input logic rev, input logic rs, input logic fr);
    int unsigned gap;
    pixel_i       <= pix;
    column_i      <= col;
    reverse_row_i <= rev;
    row_start_i   <= rs;
    first_row_i   <= fr;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sent_cnt++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_px.size() != 0);
    repeat (DRAIN_HOLD) @(posedge clk_i);
  endtask

  task automatic set_line_width(input logic [LW_W-1:0] w);
    drain_pipe();
    cfg_wdata_i <= w;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    lw_writes++;
  endtask

  // Serpentine rows over columns first_col..first_col+ncols-1; broken rows
  // drop pixels and sometimes the row start marker.
  task automatic run_rows(input int first_col, input int ncols, input int rows,
                          input bit start_rev, input bit broken);
    int c;
    bit rev, drop_rs;
    for (int r = 0; r < rows; r++) begin
      rev = start_rev ^ (r % 2 == 1);
      drop_rs = broken && ($urandom_range(0, 3) == 0);
      for (int k = 0; k < ncols; k++) begin
        if (broken && $urandom_range(0, 15) == 0) continue;
        c = rev ? first_col + ncols - 1 - k : first_col + k;
        send_pixel(rand_pixel(), COL_W'(c), rev, (k == 0) && !drop_rs, r == 0);
      end
    end
  endtask

  task automatic test_directed();
    set_line_width(LW_W'(8));
    // top row, left to right
    send_pixel(8'd0,   11'd0, 1'b0, 1'b1, 1'b1);
    send_pixel(8'd255, 11'd1, 1'b0, 1'b0, 1'b1);
    send_pixel(8'd128, 11'd2, 1'b0, 1'b0, 1'b1);
    send_pixel(8'd127, 11'd3, 1'b0, 1'b0, 1'b1);
    send_pixel(8'd254, 11'd4, 1'b0, 1'b0, 1'b1);
    send_pixel(8'd1,   11'd5, 1'b0, 1'b0, 1'b1);
    send_pixel(8'd200, 11'd6, 1'b0, 1'b0, 1'b1);
    send_pixel(8'd255, 11'd7, 1'b0, 1'b0, 1'b1);
    // next row right to left, down to column 0; diagonal off the right edge dropped
    send_pixel(8'd255, 11'd7, 1'b1, 1'b1, 1'b0);
    send_pixel(8'd0,   11'd6, 1'b1, 1'b0, 1'b0);
    send_pixel(8'd254, 11'd5, 1'b1, 1'b0, 1'b0);
    send_pixel(8'd128, 11'd4, 1'b1, 1'b0, 1'b0);
    send_pixel(8'd64,  11'd3, 1'b1, 1'b0, 1'b0);
    send_pixel(8'd255, 11'd2, 1'b1, 1'b0, 1'b0);
    send_pixel(8'd3,   11'd1, 1'b1, 1'b0, 1'b0);
    send_pixel(8'd254, 11'd0, 1'b1, 1'b0, 1'b0);
    // pile diagonal shares onto column 5 until it saturates, then read it
    send_pixel(8'd254, 11'd5, 1'b0, 1'b1, 1'b1);
    send_pixel(8'd254, 11'd4, 1'b1, 1'b1, 1'b1);
    send_pixel(8'd254, 11'd4, 1'b1, 1'b1, 1'b1);
    send_pixel(8'd255, 11'd5, 1'b0, 1'b1, 1'b0);
    // last column, far past line_width
    send_pixel(8'd255, 11'd2047, 1'b1, 1'b1, 1'b0);
    send_pixel(8'd255, 11'd2047, 1'b0, 1'b1, 1'b0);
    // widest line: diagonal into the last store entry, then read it back
    set_line_width(LW_W'(2048));
    send_pixel(8'd200, 11'd2046, 1'b1, 1'b1, 1'b0);
    send_pixel(8'd100, 11'd2047, 1'b0, 1'b0, 1'b0);
    // one-pixel rows
    set_line_width(LW_W'(1));
    send_pixel(8'd255, 11'd0, 1'b0, 1'b1, 1'b1);
    send_pixel(8'd128, 11'd0, 1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_frames();
    int lw, ncols;
    bit broken;
    while (sent_cnt < FRAME_END) begin
      case ($urandom_range(0, 9))
        0: lw = 1;
        1: lw = 2048;
        2: lw = $urandom_range(25, 64);
        default: lw = $urandom_range(2, 24);
      endcase
      if (lw != lw_q) set_line_width(LW_W'(lw));
      else if ($urandom_range(0, 3) == 0) drain_pipe();
      broken = ($urandom_range(0, 5) == 0);
      if (lw == 2048) begin
        // full rows would be too long; run the top end of the line instead
        ncols = $urandom_range(4, 12);
        run_rows(2048 - ncols, ncols, $urandom_range(1, 6), 1'($urandom_range(0, 1)), broken);
      end else begin
        run_rows(0, lw, $urandom_range(1, 6), 1'($urandom_range(0, 1)), broken);
      end
      frame_cnt++;
    end
  endtask

  task automatic test_noise();
    set_line_width(LW_W'($urandom_range(1, 2048)));
    while (sent_cnt < TOTAL_ITEMS) begin
      if (stray_cnt == 75) set_line_width(LW_W'($urandom_range(1, 64)));
      send_pixel(PIX_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 2047)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      stray_cnt++;
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    pixel_i       <= '0;
    column_i      <= '0;
    reverse_row_i <= 1'b0;
    row_start_i   <= 1'b0;
    first_row_i   <= 1'b0;
    out_ready_i   <= 1'b0;
    stall_mode    = 0;
    stall_left    = 0;
    stall_cyc     = 0;
    burst_left    = 0;
    err_cnt       = 0;
    sent_cnt      = 0;
    checked_cnt   = 0;
    lw_writes     = 0;
    frame_cnt     = 0;
    stray_cnt     = 0;
    for (int i = 0; i < MAX_WIDTH; i++) row_err_q[i] = '0;
    carry_err_q = '0;
    lw_q        = LW_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_frames();
    test_noise();
    drain_pipe();
    repeat (8) @(posedge clk_i);
    if (expected_px.size() != 0) begin
      $error("%0d expected results never arrived", expected_px.size());
      err_cnt++;
    end

    $display("Sent %0d pixels: directed edges, %0d serpentine frames, %0d stray beats;",
             sent_cnt, frame_cnt, stray_cnt);
    $display("%0d line_width writes, %0d result beats checked, %0d mismatches.",
             lw_writes, checked_cnt, err_cnt);
    if (err_cnt == 0)
      $display("** serpentine_error_diffusion_binarize_core: PASSED **");
    else
      $display("** serpentine_error_diffusion_binarize_core: FAILED **");
    $finish;
  end

endmodule

### serpentine_error_diffusion_binarize_core.f
rtl/sedb_pkg.sv
rtl/sedb_ram.sv
rtl/sedb_diffuse.sv
rtl/serpentine_error_diffusion_binarize_core.sv
tb/sv/serpentine_error_diffusion_binarize_core_tb.sv
